>>> hdl/i8mr_pkg.sv
package i8mr_pkg;

    localparam int SMP_W   = 8;
    localparam int SUM_W   = 28;
    localparam int LEN_W   = 21;
    localparam int IDX_W   = 20;
    localparam int CIDX_W  = 2;
    localparam int PROD_W  = 2 * LEN_W;
    localparam int STEP_W  = $clog2(SUM_W);

    localparam logic [LEN_W-1:0] MAX_ELEMENTS = LEN_W'(1048576);

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_GLOBAL_MODE     = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_TOTAL_ELEMENTS  = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_LAST_DIM_LENGTH = CIDX_W'(2);

    // One finished group, waiting for its division
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] len;
        logic [IDX_W-1:0] idx;
    } t_job;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > MAX_ELEMENTS) begin
            r = MAX_ELEMENTS;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> hdl/i8mr_front.sv
module i8mr_front
    import i8mr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]  i_cfg_data,
    input  logic              i_sample_valid,
    output logic              o_sample_ready,
    input  logic [SMP_W-1:0]  i_sample,
    input  logic              i_queue_full,
    output logic              o_push,
    output t_job              o_job
);

    logic              r_global_mode;
    logic [LEN_W-1:0]  r_total_elements;
    logic [LEN_W-1:0]  r_last_dim_length;
    logic [SUM_W-1:0]  r_sum;
    logic [LEN_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_gc;
    logic [PROD_W-1:0] r_bound;
    logic              r_bound_ok;

    logic [LEN_W-1:0]  total_eff;
    logic [LEN_W-1:0]  len_eff;
    logic [SUM_W-1:0]  n_sum;
    logic [LEN_W-1:0]  n_pos;
    logic              accept;
    logic              group_done;
    logic              wrap;
    logic [LEN_W-1:0]  gc_plus2;
    logic [PROD_W-1:0] n_bound;

    assign total_eff = clamp_len(r_total_elements);
    assign len_eff   = r_global_mode ? total_eff : clamp_len(r_last_dim_length);

    assign o_sample_ready = r_bound_ok && !i_queue_full;
    assign accept         = i_sample_valid && o_sample_ready;

    assign n_sum      = r_sum + {{(SUM_W-SMP_W){i_sample[SMP_W-1]}}, i_sample};
    assign n_pos      = r_pos + LEN_W'(1);
    assign group_done = (n_pos >= len_eff);

    // Index wraps in global mode, or once the next group would run past the tensor:
    // total < (index + 2) * length.
    assign gc_plus2 = {1'b0, r_gc} + LEN_W'(2);
    assign n_bound  = {{(PROD_W-LEN_W){1'b0}}, gc_plus2}
                    * {{(PROD_W-LEN_W){1'b0}}, len_eff};
    assign wrap    = r_global_mode || ({{(PROD_W-LEN_W){1'b0}}, total_eff} < r_bound);

    assign o_push      = accept && group_done;
    assign o_job.sum   = n_sum;
    assign o_job.len   = len_eff;
    assign o_job.idx   = r_gc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_mode     <= 1'b1;
            r_total_elements  <= LEN_W'(1);
            r_last_dim_length <= LEN_W'(1);
            r_sum             <= '0;
            r_pos             <= '0;
            r_gc              <= '0;
            r_bound_ok        <= 1'b0;
        end else begin
            // bound is registered from the index and config, so ready drops while it catches up
            r_bound_ok <= !(o_push || i_cfg_wr_en);
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_GLOBAL_MODE:     r_global_mode     <= i_cfg_data[0];
                    CFG_TOTAL_ELEMENTS:  r_total_elements  <= i_cfg_data;
                    CFG_LAST_DIM_LENGTH: r_last_dim_length <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (group_done) begin
                    r_sum <= '0;
                    r_pos <= '0;
                    r_gc  <= wrap ? '0 : r_gc + IDX_W'(1);
                end else begin
                    r_sum <= n_sum;
                    r_pos <= n_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bound <= n_bound;
    end

endmodule

>>> hdl/i8mr_queue.sv
module i8mr_queue
    import i8mr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

>>> hdl/i8mr_divider.sv
module i8mr_divider
    import i8mr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  t_job             i_job,
    output logic             o_result_valid,
    input  logic             i_result_ready,
    output logic [SMP_W-1:0] o_mean_value,
    output logic [IDX_W-1:0] o_group_index
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [STEP_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_dvd;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_len;
    logic [SMP_W-1:0]  r_q;
    logic              r_neg;
    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [SMP_W-1:0]  r_out_mean;
    logic [IDX_W-1:0]  r_out_idx;

    logic [LEN_W:0]    rem_shift;
    logic [LEN_W:0]    diff;
    logic              fits;
    logic              out_free;

    assign o_job_ready = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_result_ready;

    assign rem_shift = {r_rem, r_dvd[SUM_W-1]};
    assign diff      = rem_shift - {1'b0, r_len};
    assign fits      = (rem_shift >= {1'b0, r_len});

    assign o_result_valid = r_out_valid;
    assign o_mean_value   = r_out_mean;
    assign o_group_index  = r_out_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a finishing divide reloads the output itself
            if (r_out_valid && i_result_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid) begin
            r_neg <= i_job.sum[SUM_W-1];
            r_dvd <= i_job.sum[SUM_W-1] ? SUM_W'(-i_job.sum) : i_job.sum;
            r_len <= i_job.len;
            r_idx <= i_job.idx;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= STEP_W'(SUM_W - 1);
        end else if (r_state == S_DIV) begin
            r_rem <= fits ? diff[LEN_W-1:0] : rem_shift[LEN_W-1:0];
            r_dvd <= {r_dvd[SUM_W-2:0], 1'b0};
            r_q   <= {r_q[SMP_W-2:0], fits};
            r_cnt <= r_cnt - STEP_W'(1);
        end
        if (r_state == S_DONE && out_free) begin
            r_out_mean <= r_neg ? SMP_W'(-r_q) : r_q;
            r_out_idx  <= r_idx;
        end
    end

endmodule

>>> hdl/int8_mean_reduction_top.sv
// Path: a request that closes a group is pushed into the queue; its mean follows
//   the divider load, 28 divider steps and the load of the output register.
// Throughput: one request per cycle inside a group while the queue has room; the
//   input pauses after each closing request; the divider takes a group only when idle.
// Reset: synchronous, active low; clears sums, counters, queue and output valid,
//   and loads global_mode=1, total_elements=1, last_dim_length=1.
module int8_mean_reduction_top
    import i8mr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_wr_en,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]  i_cfg_data,
    // sample channel
    input  logic              i_sample_valid,
    output logic              o_sample_ready,
    input  logic [SMP_W-1:0]  i_sample,
    // result channel
    output logic              o_result_valid,
    input  logic              i_result_ready,
    output logic [SMP_W-1:0]  o_mean_value,
    output logic [IDX_W-1:0]  o_group_index
);

    // Front end: hold the config, accumulate each request into the running sum,
    // and when a group closes hand its sum, length and index to the queue.
    logic queue_full;
    logic push;
    t_job push_job;

    // Back end: pull finished groups and divide them one bit per cycle.
    logic queue_valid;
    logic pop;
    t_job pop_job;

    i8mr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .i_queue_full   (queue_full),
        .o_push         (push),
        .o_job          (push_job)
    );

    // Two-entry queue decouples accumulation from division, so sampling keeps
    // running while a previous group is still being divided.
    i8mr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_job   (pop_job)
    );

    // Restoring divider on the sum magnitude; sign applied at the end so the
    // quotient truncates toward zero. The result sits in an output register.
    i8mr_divider u_divider (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (queue_valid),
        .o_job_ready    (pop),
        .i_job          (pop_job),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_mean_value   (o_mean_value),
        .o_group_index  (o_group_index)
    );

endmodule

>>> bench/tb.sv
module tb;
    import i8mr_pkg::*;

    // Spare register index: the block must ignore writes to it
    localparam logic [CIDX_W-1:0] CFG_SPARE = CIDX_W'(3);

    // Cycles to let pass once nothing is expected, before touching the registers
    localparam int SETTLE_CYCLES = 40;
    // Watchdog: several times the slowest legal run (one mean per request,
    // every request and every mean held up by the longest gap)
    localparam int LIMIT_CYCLES = 5_000_000;
    localparam int ITEM_TARGET = 1450;

    typedef enum int {MIX_FULL, MIX_RAILS, MIX_NEAR_ZERO, MIX_LOW} t_sample_mix;

    // Predicts the group means and checks them in order of arrival
    class mean_scoreboard;
        typedef struct packed {
            logic [SMP_W-1:0] mean;
            logic [IDX_W-1:0] grp;
        } t_mean_exp;

        bit             whole_tensor;
        bit [LEN_W-1:0] tensor_size;
        bit [LEN_W-1:0] row_size;
        bit [SUM_W-1:0] acc;
        bit [LEN_W-1:0] fill;
        bit [IDX_W-1:0] grp;
        t_mean_exp      pending[$];
        int             errors;

        function new();
            whole_tensor = 1'b1;
            tensor_size  = LEN_W'(1);
            row_size     = LEN_W'(1);
            acc          = '0;
            fill         = '0;
            grp          = '0;
            errors       = 0;
        endfunction

        // Zero counts as one, anything past the maximum is clamped
        function int fit_length(bit [LEN_W-1:0] v);
            if (v == '0) return 1;
            if (v > MAX_ELEMENTS) return int'(MAX_ELEMENTS);
            return int'(v);
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [LEN_W-1:0] val);
            case (idx)
                CFG_GLOBAL_MODE:     whole_tensor = val[0];
                CFG_TOTAL_ELEMENTS:  tensor_size  = val;
                CFG_LAST_DIM_LENGTH: row_size     = val;
                default: ;
            endcase
        endfunction

        // Fold one accepted sample in; queue a mean when its group closes
        function void note_sample(logic [SMP_W-1:0] s);
            int        total;
            int        len;
            int        groups;
            longint    quo;
            t_mean_exp e;
            total = fit_length(tensor_size);
            if (whole_tensor) begin
                len    = total;
                groups = 1;
            end else begin
                len    = fit_length(row_size);
                groups = total / len;
                if (groups == 0) groups = 1;
            end
            acc  = acc + {{(SUM_W-SMP_W){s[SMP_W-1]}}, s};
            fill = fill + 1'b1;
            if (fill < len) return;
            // Integer division truncates toward zero
            quo    = longint'($signed(acc)) / longint'(len);
            e.mean = quo[SMP_W-1:0];
            e.grp  = grp;
            pending.push_back(e);
            acc  = '0;
            fill = '0;
            if (int'(grp) + 1 >= groups) grp = '0;
            else grp = grp + 1'b1;
        endfunction

        function int waiting();
            return pending.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100) $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_mean(logic [SMP_W-1:0] m, logic [IDX_W-1:0] g);
            t_mean_exp e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected mean %0d for group %0d", $signed(m), g));
                return;
            end
            e = pending.pop_front();
            if (m !== e.mean)
                report($sformatf("group %0d: mean %0d, want %0d",
                                 e.grp, $signed(m), $signed(e.mean)));
            if (g !== e.grp)
                report($sformatf("group index %0d, want %0d", g, e.grp));
        endtask
    endclass

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_wr_en    = 1'b0;
    logic [CIDX_W-1:0] i_cfg_index    = '0;
    logic [LEN_W-1:0]  i_cfg_data     = '0;
    logic              i_sample_valid = 1'b0;
    logic              o_sample_ready;
    logic [SMP_W-1:0]  i_sample       = '0;
    logic              o_result_valid;
    logic              i_result_ready = 1'b0;
    logic [SMP_W-1:0]  o_mean_value;
    logic [IDX_W-1:0]  o_group_index;

    mean_scoreboard sb;
    bit             calm = 1'b0;   // set: neither side inserts gaps
    int             hold_cnt = 0;
    int             items_sent = 0;

    int8_mean_reduction_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_mean_value   (o_mean_value),
        .o_group_index  (o_group_index)
    );

    always #5 i_clk = ~i_clk;

    // Gap length: mostly short, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Group length: mostly short, a few up to a couple hundred
    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 45) return $urandom_range(1, 6);
        if (r < 85) return $urandom_range(7, 32);
        return $urandom_range(33, 200);
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample(t_sample_mix mix);
        case (mix)
            MIX_RAILS:     return $urandom_range(1) ? 8'h7F : 8'h80;
            MIX_NEAR_ZERO: return SMP_W'($urandom_range(6)) - 8'd3;
            MIX_LOW:       return 8'h80 + SMP_W'($urandom_range(40));
            default:       return SMP_W'($urandom_range(255));
        endcase
    endfunction

    // Result side: stall at random unless calm; sample the handshake before the edge
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt       <= hold_cnt - 1;
            i_result_ready <= 1'b0;
        end else if (!calm && $urandom_range(3) == 0) begin
            hold_cnt       <= pick_gap();
            i_result_ready <= 1'b0;
        end else begin
            i_result_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid && i_result_ready)
            sb.check_mean(o_mean_value, o_group_index);
    end

    // Drive one register for exactly one edge, then drop the enable
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold the request until accepted; keep valid high when the next one follows at once
    task automatic send_sample(input logic [SMP_W-1:0] v);
        int gap;
        i_sample_valid <= 1'b1;
        i_sample       <= v;
        do @(posedge i_clk); while (!o_sample_ready);
        sb.note_sample(v);
        items_sent++;
        gap = (!calm && $urandom_range(2) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop the request line and wait until every predicted mean has come back
    task automatic wait_idle();
        i_sample_valid <= 1'b0;
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One random setting followed by mostly whole groups of samples
    task automatic run_phase();
        bit               glob;
        int               len;
        int               n;
        int               g;
        int               r;
        logic [LEN_W-1:0] tot;
        logic [LEN_W-1:0] row;
        t_sample_mix      mix;
        glob = ($urandom_range(9) < 3);
        len  = pick_len();
        calm = ($urandom_range(3) == 0);
        mix  = t_sample_mix'($urandom_range(3));
        if (glob) begin
            // Whole tensor is one group; the row length is never used here,
            // so load it with extremes freely
            tot = (len == 1 && $urandom_range(1)) ? '0 : LEN_W'(len);
            row = $urandom_range(1) ? '1 : LEN_W'($urandom_range(2 ** LEN_W - 1));
            n   = len * $urandom_range(1, len > 32 ? 2 : 5);
        end else begin
            g = $urandom_range(1, 6);
            r = $urandom_range(99);
            if (r < 60) tot = LEN_W'(len * g + $urandom_range(len - 1));
            else if (r < 75) tot = LEN_W'($urandom_range(len - 1));  // less than one row
            else if (r < 85) tot = '0;
            else if (r < 93) tot = '1;                                 // clamps to maximum
            else tot = LEN_W'($urandom_range(int'(MAX_ELEMENTS) + 1, 2 ** LEN_W - 1));
            row = (len == 1 && $urandom_range(1)) ? '0 : LEN_W'(len);
            // Often more rows than the tensor holds, so the group index can wrap
            n   = len * $urandom_range(1, len > 32 ? 2 : 7);
        end
        // Leave a partial group behind for the next setting to finish
        if ($urandom_range(3) == 0) n += $urandom_range(len - 1);
        // Stop close to the item budget
        if (n > ITEM_TARGET - items_sent) n = ITEM_TARGET - items_sent;

        write_reg(CFG_GLOBAL_MODE, LEN_W'(glob));
        write_reg(CFG_TOTAL_ELEMENTS, tot);
        write_reg(CFG_LAST_DIM_LENGTH, row);
        if ($urandom_range(4) == 0) write_reg(CFG_SPARE, LEN_W'($urandom));

        for (int i = 0; i < n; i++) begin
            send_sample(pick_sample(mix));
            if ($urandom_range(49) == 0) wait_idle();
        end
        wait_idle();
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset setting: global, one element, so every sample is its own mean
        send_sample(8'h7F);
        send_sample(8'h80);
        send_sample(8'h00);
        send_sample(8'hFF);
        send_sample(8'h55);
        send_sample(8'hAA);
        wait_idle();

        // Ignored spare write, then zero lengths that must act as one
        write_reg(CFG_SPARE, '1);
        write_reg(CFG_GLOBAL_MODE, '0);
        write_reg(CFG_LAST_DIM_LENGTH, '0);
        write_reg(CFG_TOTAL_ELEMENTS, '0);
        send_sample(8'h12);
        send_sample(8'hED);
        wait_idle();

        // Rows of three in a tensor of seven: two rows, then the index wraps.
        // Full-scale means, a small negative sum that truncates to zero,
        // then a partial row left open
        write_reg(CFG_LAST_DIM_LENGTH, LEN_W'(3));
        write_reg(CFG_TOTAL_ELEMENTS, LEN_W'(7));
        repeat (3) send_sample(8'h80);
        repeat (3) send_sample(8'h7F);
        send_sample(8'hFF);
        send_sample(8'hFF);
        send_sample(8'h01);
        send_sample(8'hFD);
        send_sample(8'hFE);
        wait_idle();

        // Shorten the row under the open group: the next sample closes it
        write_reg(CFG_LAST_DIM_LENGTH, LEN_W'(2));
        send_sample(8'h00);
        wait_idle();

        while (items_sent < ITEM_TARGET) run_phase();

        if (sb.errors == 0) begin
            $display("int8_mean_reduction_top: match");
        end else begin
            $display("int8_mean_reduction_top: mismatch");
        end
        $finish;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("int8_mean_reduction_top: mismatch");
        $finish;
    end

endmodule
